// File: hdl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Types, codes and small tables shared by the quaternion accumulator modules.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int SQ_BITS   = 128;  // sum-of-squares / sqrt radicand frame
  localparam int ROOT_BITS = 64;
  localparam int REM_BITS  = 68;
  localparam int SCAL_BITS = 31;
  localparam int CMD_BITS  = 4;
  localparam int STAT_BITS = 2;
  localparam logic [ROOT_BITS-1:0] SCAL_MAX = 64'h0000_0000_7FFF_FFFF;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD     = 4'd0,
    CMD_MUL      = 4'd1,
    CMD_ADD      = 4'd2,
    CMD_SCALE    = 4'd3,
    CMD_NORMLZ   = 4'd4,
    CMD_CONJ     = 4'd5,
    CMD_ROTATE   = 4'd6,
    CMD_NORM     = 4'd7,
    CMD_FRAC     = 4'd8,
    CMD_BETWEEN  = 4'd9
  } cmd_e;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK   = 2'd0,
    STAT_SAT  = 2'd1,
    STAT_ZERO = 2'd2
  } stat_e;

  // product-sum flavors run on the shared multiplier
  typedef enum logic [2:0] {
    K_HAM_AQ,   // A * Q
    K_HAM_TC,   // T * conj(A)
    K_SCALE,    // A * s
    K_FRAC,     // fractional rotation blend
    K_BTW,      // A * Q with 1 - w on the real part
    K_SUMSQ     // sum of squares of T
  } kind_e;

  // program steps of one command
  typedef enum logic [3:0] {
    P_LOAD, P_ADD, P_CONJ, P_COPY, P_COMMIT,
    P_HAM1, P_HAM2, P_SCALE, P_FRAC, P_BTW,
    P_NORMQ, P_NORM, P_END
  } step_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ADD, OP_CONJ, OP_COPY, OP_COMMIT,
    OP_MUL, OP_ACC, OP_FIN, OP_SQ_LOAD, OP_SHIFT, OP_SQRT,
    OP_NORM_OUT, OP_ZERO, OP_DLOAD, OP_DIV, OP_DFIN
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_MUL, S_ACC, S_FIN, S_SQCHK, S_SHIFT,
    S_SQRT, S_SCAL, S_DLOAD, S_DIV, S_DFIN, S_OUT
  } state_e;

  typedef struct packed {
    logic       latch;
    op_e        op;
    kind_e      kind;
    logic [1:0] comp;
    logic [2:0] term;
    logic       first;
    logic       rot;
  } ctrl_t;

  typedef struct packed {
    logic acc_zero;
    logic sc_top_zero;
  } dstat_t;

  // Hamilton sign table, row i = component, column t = term
  localparam logic [15:0] HN_TAB = 16'b0100_0010_1000_1110;

  function automatic logic hn(input logic [1:0] i, input logic [1:0] t);
    return HN_TAB[{i, t}];
  endfunction

  function automatic logic [2:0] nterms(input kind_e k, input logic [1:0] comp);
    logic [2:0] n;
    case (k)
      K_SCALE: n = 3'd1;
      K_FRAC:  n = (comp == 2'd0) ? 3'd3 : 3'd1;
      K_BTW:   n = (comp == 2'd0) ? 3'd5 : 3'd4;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/quaternion_accumulator_unit.sv
// ----------------------------------------------------------------------------
// quaternion_accumulator_unit
// Fixed-point quaternion accumulator with Hamilton product, rotation and
// normalization commands on a stream interface.
// ----------------------------------------------------------------------------
// One item is taken at a time; the next is accepted once the result item has
// been taken. Products run one term at a time, a multiply state then an
// accumulate state, on a single shared multiplier. Normalize, fractional and
// between add a leading-zero shift, a digit-serial square root and four
// restoring divides; norm adds a square root without the shift.
// ----------------------------------------------------------------------------
module quaternion_accumulator_unit import qau_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // operand_w, operand_x, operand_y, operand_z, operand_scalar
  input  logic [((5*WORD_BITS+7)/8)*8-1:0]       s_axis_tdata_i,
  // command
  input  logic [CMD_BITS-1:0]                    s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // result_w, result_x, result_y, result_z, result_scalar
  output logic [((4*WORD_BITS+SCAL_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic [STAT_BITS-1:0]                   m_axis_tuser_o
);

  localparam int W        = WORD_BITS;
  localparam int OUT_BITS = ((4*WORD_BITS+SCAL_BITS+7)/8)*8;
  localparam int OUT_PAD  = OUT_BITS - 4*W - SCAL_BITS;

  ctrl_t                ctrl;
  dstat_t               dstat;
  logic signed [W-1:0]  res_w, res_x, res_y, res_z;
  logic [SCAL_BITS-1:0] res_scal;

  qau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .cmd_i     (s_axis_tuser_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .ctrl_o    (ctrl),
    .dstat_i   (dstat)
  );

  qau_dpath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .dstat_o    (dstat),
    .in_w_i     ($signed(s_axis_tdata_i[0*W +: W])),
    .in_x_i     ($signed(s_axis_tdata_i[1*W +: W])),
    .in_y_i     ($signed(s_axis_tdata_i[2*W +: W])),
    .in_z_i     ($signed(s_axis_tdata_i[3*W +: W])),
    .in_s_i     ($signed(s_axis_tdata_i[4*W +: W])),
    .res_w_o    (res_w),
    .res_x_o    (res_x),
    .res_y_o    (res_y),
    .res_z_o    (res_z),
    .res_scal_o (res_scal),
    .status_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{OUT_PAD{1'b0}}, res_scal, res_z, res_y, res_x, res_w};

endmodule

// File: hdl/qau_ctrl.sv
// ----------------------------------------------------------------------------
// qau_ctrl
// Command sequencer: walks the step program of each command and drives the
// datapath through multiply-accumulate, square-root and divide passes.
// ----------------------------------------------------------------------------
module qau_ctrl import qau_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [CMD_BITS-1:0] cmd_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output ctrl_t               ctrl_o,
  input  dstat_t              dstat_i
);

  state_e              state_q, state_d;
  logic [CMD_BITS-1:0] cmd_q, cmd_d;
  logic [1:0]          idx_q, idx_d;
  logic [1:0]          comp_q, comp_d;
  logic [2:0]          term_q, term_d;
  logic [6:0]          cnt_q, cnt_d;
  step_e               step;
  kind_e               kind;

  function automatic step_e prog(input logic [CMD_BITS-1:0] c, input logic [1:0] i);
    step_e s;
    s = P_END;
    case (c)
      CMD_LOAD:    s = (i == 2'd0) ? P_LOAD : P_END;
      CMD_MUL:     s = (i == 2'd0) ? P_HAM1 : (i == 2'd1) ? P_COMMIT : P_END;
      CMD_ADD:     s = (i == 2'd0) ? P_ADD : P_END;
      CMD_SCALE:   s = (i == 2'd0) ? P_SCALE : (i == 2'd1) ? P_COMMIT : P_END;
      CMD_NORMLZ:  s = (i == 2'd0) ? P_COPY : (i == 2'd1) ? P_NORMQ :
                       (i == 2'd2) ? P_COMMIT : P_END;
      CMD_CONJ:    s = (i == 2'd0) ? P_CONJ : P_END;
      CMD_ROTATE:  s = (i == 2'd0) ? P_HAM1 : (i == 2'd1) ? P_HAM2 : P_END;
      CMD_NORM:    s = (i == 2'd0) ? P_COPY : (i == 2'd1) ? P_NORM : P_END;
      CMD_FRAC:    s = (i == 2'd0) ? P_FRAC : (i == 2'd1) ? P_NORMQ :
                       (i == 2'd2) ? P_COMMIT : P_END;
      CMD_BETWEEN: s = (i == 2'd0) ? P_BTW : (i == 2'd1) ? P_NORMQ :
                       (i == 2'd2) ? P_COMMIT : P_END;
      default:     s = P_END;
    endcase
    return s;
  endfunction

  always_comb begin
    step = prog(cmd_q, idx_q);
    case (step)
      P_HAM1:  kind = K_HAM_AQ;
      P_HAM2:  kind = K_HAM_TC;
      P_SCALE: kind = K_SCALE;
      P_FRAC:  kind = K_FRAC;
      P_BTW:   kind = K_BTW;
      default: kind = K_SUMSQ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    comp_d  = comp_q;
    term_d  = term_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_d   = cmd_i;
          idx_d   = 2'd0;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        case (step)
          P_LOAD, P_ADD, P_CONJ, P_COPY, P_COMMIT: idx_d = idx_q + 2'd1;
          P_END: state_d = S_OUT;
          default: begin
            comp_d  = 2'd0;
            term_d  = 3'd0;
            state_d = S_MUL;
          end
        endcase
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        if (term_q == nterms(kind, comp_q) - 3'd1) begin
          term_d  = 3'd0;
          state_d = (kind == K_SUMSQ) ? S_SQCHK : S_FIN;
        end else begin
          term_d  = term_q + 3'd1;
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        if (comp_q == 2'd3) begin
          comp_d  = 2'd0;
          idx_d   = idx_q + 2'd1;
          state_d = S_STEP;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_SQCHK: begin
        if (step == P_NORM) begin
          cnt_d   = 7'd63;
          state_d = S_SQRT;
        end else if (dstat_i.acc_zero) begin
          idx_d   = idx_q + 2'd1;
          state_d = S_STEP;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!dstat_i.sc_top_zero) begin
          cnt_d   = 7'd63;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd0) begin
          comp_d  = 2'd0;
          state_d = (step == P_NORM) ? S_SCAL : S_DLOAD;
        end
      end
      S_SCAL: begin
        idx_d   = idx_q + 2'd1;
        state_d = S_STEP;
      end
      S_DLOAD: begin
        cnt_d   = 7'd127;
        state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd0) state_d = S_DFIN;
      end
      S_DFIN: begin
        if (comp_q == 2'd3) begin
          comp_d  = 2'd0;
          idx_d   = idx_q + 2'd1;
          state_d = S_STEP;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_DLOAD;
        end
      end
      S_OUT: begin
        if (m_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o       = '0;
    ctrl_o.op    = OP_NONE;
    ctrl_o.kind  = kind;
    ctrl_o.comp  = comp_q;
    ctrl_o.term  = term_q;
    ctrl_o.first = (term_q == 3'd0);
    ctrl_o.rot   = (cmd_q == CMD_ROTATE);
    s_ready_o    = 1'b0;
    m_valid_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o    = 1'b1;
        ctrl_o.latch = s_valid_i;
      end
      S_STEP: begin
        case (step)
          P_LOAD:   ctrl_o.op = OP_LOAD;
          P_ADD:    ctrl_o.op = OP_ADD;
          P_CONJ:   ctrl_o.op = OP_CONJ;
          P_COPY:   ctrl_o.op = OP_COPY;
          P_COMMIT: ctrl_o.op = OP_COMMIT;
          default:  ctrl_o.op = OP_NONE;
        endcase
      end
      S_MUL:   ctrl_o.op = OP_MUL;
      S_ACC:   ctrl_o.op = OP_ACC;
      S_FIN:   ctrl_o.op = OP_FIN;
      S_SQCHK: begin
        if (step == P_NORM || !dstat_i.acc_zero) ctrl_o.op = OP_SQ_LOAD;
        else                                     ctrl_o.op = OP_ZERO;
      end
      S_SHIFT: ctrl_o.op = dstat_i.sc_top_zero ? OP_SHIFT : OP_NONE;
      S_SQRT:  ctrl_o.op = OP_SQRT;
      S_SCAL:  ctrl_o.op = OP_NORM_OUT;
      S_DLOAD: ctrl_o.op = OP_DLOAD;
      S_DIV:   ctrl_o.op = OP_DIV;
      S_DFIN:  ctrl_o.op = OP_DFIN;
      S_OUT:   m_valid_o = 1'b1;
      default: ctrl_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      idx_q   <= '0;
      comp_q  <= '0;
      term_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      comp_q  <= comp_d;
      term_q  <= term_d;
      cnt_q   <= cnt_d;
    end
  end

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o |-> !s_ready_o)
    else $error("input ready while a result is pending");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_STEP && idx_q == 2'd0))
    else $error("accepted item did not start its program");

  a_out_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_ready_i) |=> s_ready_o)
    else $error("not ready after result delivered");

  a_div_in_normq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step == P_NORMQ))
    else $error("divide outside normalize step");

endmodule

// File: hdl/qau_dpath.sv
// ----------------------------------------------------------------------------
// qau_dpath
// Accumulator, temporaries, shared multiply-accumulate, digit-serial square
// root and restoring divider of the quaternion accumulator.
// ----------------------------------------------------------------------------
module qau_dpath import qau_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctrl_t                       ctrl_i,
  output dstat_t                      dstat_o,
  input  logic signed [WORD_BITS-1:0] in_w_i,
  input  logic signed [WORD_BITS-1:0] in_x_i,
  input  logic signed [WORD_BITS-1:0] in_y_i,
  input  logic signed [WORD_BITS-1:0] in_z_i,
  input  logic signed [WORD_BITS-1:0] in_s_i,
  output logic signed [WORD_BITS-1:0] res_w_o,
  output logic signed [WORD_BITS-1:0] res_x_o,
  output logic signed [WORD_BITS-1:0] res_y_o,
  output logic signed [WORD_BITS-1:0] res_z_o,
  output logic [SCAL_BITS-1:0]        res_scal_o,
  output logic [STAT_BITS-1:0]        status_o
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W + 1;
  localparam int AW = 2 * W + 4;
  localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  ONE_Q  = W'(64'd1 << FRAC_BITS);
  localparam logic signed [AW-1:0] WMAX_A = $signed({{(AW-W){1'b0}}, WMAX});
  localparam logic signed [AW-1:0] WMIN_A = $signed({{(AW-W){1'b1}}, WMIN});
  localparam logic signed [AW-1:0] HALF_A = AW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [ROOT_BITS-1:0] QMAX_P = ROOT_BITS'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [ROOT_BITS-1:0] QMAX_N = ROOT_BITS'(64'd1 << (W - 1));

  logic signed [W-1:0]      a_q [4];
  logic signed [W-1:0]      t_q [4];
  logic signed [W-1:0]      v_q [4];
  logic signed [W-1:0]      q_q [4];
  logic signed [W-1:0]      s_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [AW-1:0]     acc_q;
  logic [SQ_BITS-1:0]       sc_q;
  logic [REM_BITS-1:0]      rem_q;
  logic [ROOT_BITS-1:0]     root_q;
  logic [5:0]               k_q;
  logic [SQ_BITS-1:0]       num_q;
  logic [ROOT_BITS:0]       r_q;
  logic [ROOT_BITS-1:0]     quo_q;
  logic                     sat_q, zero_q;
  logic [SCAL_BITS-1:0]     scal_q;

  // operand select
  logic signed [W-1:0]   op_x, op_y;
  logic                  op_neg;
  logic [1:0]            tj, tt, ci;
  logic signed [2*W-1:0] mul;

  always_comb begin
    ci     = ctrl_i.comp;
    tt     = ctrl_i.term[1:0];
    tj     = ci ^ tt;
    op_x   = a_q[tt];
    op_y   = q_q[tj];
    op_neg = hn(ci, tt);
    case (ctrl_i.kind)
      K_HAM_AQ: ;
      K_HAM_TC: begin
        op_x   = t_q[tt];
        op_y   = a_q[tj];
        op_neg = hn(ci, tt) ^ (tj != 2'd0);
      end
      K_SCALE: begin
        op_x   = a_q[ci];
        op_y   = s_q;
        op_neg = 1'b0;
      end
      K_FRAC: begin
        op_neg = 1'b0;
        if (ci != 2'd0) begin
          op_x = s_q;
          op_y = a_q[ci];
        end else if (ctrl_i.term == 3'd0) begin
          op_x = ONE_Q;
          op_y = ONE_Q;
        end else if (ctrl_i.term == 3'd1) begin
          op_x   = s_q;
          op_y   = ONE_Q;
          op_neg = 1'b1;
        end else begin
          op_x = s_q;
          op_y = a_q[0];
        end
      end
      K_BTW: begin
        if (ctrl_i.term == 3'd4) begin
          op_x   = ONE_Q;
          op_y   = ONE_Q;
          op_neg = 1'b0;
        end else if (ci == 2'd0) begin
          op_neg = ~hn(ci, tt);
        end
      end
      K_SUMSQ: begin
        op_x   = t_q[tt];
        op_y   = t_q[tt];
        op_neg = 1'b0;
      end
      default: ;
    endcase
  end

  assign mul = op_x * op_y;

  // round half up, then saturate
  logic signed [AW-1:0] fin_rnd, fin_sh;
  logic signed [W-1:0]  fin_val;
  logic                 fin_sat;

  always_comb begin
    fin_rnd = acc_q + HALF_A;
    fin_sh  = fin_rnd >>> FRAC_BITS;
    fin_sat = 1'b1;
    if (fin_sh > WMAX_A)      fin_val = WMAX;
    else if (fin_sh < WMIN_A) fin_val = WMIN;
    else begin
      fin_val = fin_sh[W-1:0];
      fin_sat = 1'b0;
    end
  end

  function automatic logic [W:0] clamp1(input logic signed [W:0] v);
    if (v > $signed({WMAX[W-1], WMAX}))      return {1'b1, WMAX};
    else if (v < $signed({WMIN[W-1], WMIN})) return {1'b1, WMIN};
    else                                     return {1'b0, v[W-1:0]};
  endfunction

  logic [W:0] add_c [4];
  logic [W:0] neg_c [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      add_c[i] = clamp1($signed({a_q[i][W-1], a_q[i]}) + $signed({q_q[i][W-1], q_q[i]}));
      neg_c[i] = clamp1(-$signed({a_q[i][W-1], a_q[i]}));
    end
  end

  // square root step
  logic [REM_BITS-1:0] sq_rn, sq_trial;
  logic                sq_ge;

  assign sq_rn    = {rem_q[REM_BITS-3:0], sc_q[SQ_BITS-1 -: 2]};
  assign sq_trial = REM_BITS'({root_q, 2'b01});
  assign sq_ge    = sq_rn >= sq_trial;

  // divide step and rounding
  logic [ROOT_BITS:0]   dv_d, dv_rn, dv_diff;
  logic                 dv_ge, dv_up, t_neg;
  logic [ROOT_BITS-1:0] dv_q;
  logic [W-1:0]         t_mag;
  logic [6:0]           dv_sh;

  always_comb begin
    dv_d    = {1'b0, root_q};
    dv_rn   = {r_q[ROOT_BITS-1:0], num_q[SQ_BITS-1]};
    dv_ge   = dv_rn >= dv_d;
    dv_diff = dv_d - r_q;
    dv_up   = r_q >= dv_diff;
    dv_q    = quo_q + ROOT_BITS'(dv_up);
    t_neg   = t_q[ci][W-1];
    t_mag   = t_neg ? (~t_q[ci] + W'(1)) : t_q[ci];
    dv_sh   = 7'(FRAC_BITS) + 7'(k_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q[0] <= ONE_Q;
      a_q[1] <= '0;
      a_q[2] <= '0;
      a_q[3] <= '0;
      sat_q  <= 1'b0;
      zero_q <= 1'b0;
      scal_q <= '0;
    end else begin
      if (ctrl_i.latch) begin
        sat_q  <= 1'b0;
        zero_q <= 1'b0;
        scal_q <= '0;
      end
      case (ctrl_i.op)
        OP_LOAD: for (int i = 0; i < 4; i++) a_q[i] <= q_q[i];
        OP_ADD: begin
          for (int i = 0; i < 4; i++) a_q[i] <= add_c[i][W-1:0];
          if (add_c[0][W] | add_c[1][W] | add_c[2][W] | add_c[3][W]) sat_q <= 1'b1;
        end
        OP_CONJ: begin
          for (int i = 1; i < 4; i++) a_q[i] <= neg_c[i][W-1:0];
          if (neg_c[1][W] | neg_c[2][W] | neg_c[3][W]) sat_q <= 1'b1;
        end
        OP_COMMIT: for (int i = 0; i < 4; i++) a_q[i] <= t_q[i];
        OP_FIN:  if (fin_sat) sat_q <= 1'b1;
        OP_ZERO: zero_q <= 1'b1;
        OP_NORM_OUT: begin
          if (root_q > SCAL_MAX) begin
            scal_q <= SCAL_MAX[SCAL_BITS-1:0];
            sat_q  <= 1'b1;
          end else begin
            scal_q <= root_q[SCAL_BITS-1:0];
          end
        end
        OP_DFIN: begin
          if (t_neg ? (dv_q > QMAX_N) : (dv_q > QMAX_P)) sat_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      q_q[0] <= in_w_i;
      q_q[1] <= in_x_i;
      q_q[2] <= in_y_i;
      q_q[3] <= in_z_i;
      s_q    <= in_s_i;
    end
    case (ctrl_i.op)
      OP_COPY: for (int i = 0; i < 4; i++) t_q[i] <= a_q[i];
      OP_MUL:  prod_q <= op_neg ? -$signed({mul[2*W-1], mul}) : $signed({mul[2*W-1], mul});
      OP_ACC:  acc_q  <= (ctrl_i.first ? '0 : acc_q) + $signed({{(AW-PW){prod_q[PW-1]}}, prod_q});
      OP_FIN: begin
        if (ctrl_i.kind == K_HAM_TC) v_q[ci] <= fin_val;
        else                         t_q[ci] <= fin_val;
      end
      OP_SQ_LOAD: begin
        sc_q   <= SQ_BITS'(acc_q);
        rem_q  <= '0;
        root_q <= '0;
        k_q    <= '0;
      end
      OP_SHIFT: begin
        sc_q <= sc_q << 2;
        k_q  <= k_q + 6'd1;
      end
      OP_SQRT: begin
        sc_q <= sc_q << 2;
        if (sq_ge) begin
          rem_q  <= sq_rn - sq_trial;
          root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_q  <= sq_rn;
          root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
        end
      end
      OP_DLOAD: begin
        num_q <= SQ_BITS'(t_mag) << dv_sh;
        r_q   <= '0;
        quo_q <= '0;
      end
      OP_DIV: begin
        num_q <= num_q << 1;
        r_q   <= dv_ge ? (dv_rn - dv_d) : dv_rn;
        quo_q <= {quo_q[ROOT_BITS-2:0], dv_ge};
      end
      OP_DFIN: begin
        if (t_neg) t_q[ci] <= (dv_q > QMAX_N) ? WMIN : -$signed(dv_q[W-1:0]);
        else       t_q[ci] <= (dv_q > QMAX_P) ? WMAX : $signed(dv_q[W-1:0]);
      end
      default: ;
    endcase
  end

  assign dstat_o.acc_zero    = (acc_q == '0);
  assign dstat_o.sc_top_zero = (sc_q[SQ_BITS-1 -: 4] == 4'd0);

  assign res_w_o    = ctrl_i.rot ? v_q[0] : a_q[0];
  assign res_x_o    = ctrl_i.rot ? v_q[1] : a_q[1];
  assign res_y_o    = ctrl_i.rot ? v_q[2] : a_q[2];
  assign res_z_o    = ctrl_i.rot ? v_q[3] : a_q[3];
  assign res_scal_o = scal_q;
  assign status_o   = zero_q ? STAT_ZERO : (sat_q ? STAT_SAT : STAT_OK);

endmodule
